[rtl/d2q9_pkg.sv]
// ----------------------------------------------------------------------------
// d2q9_pkg
// Shared constants for the D2Q9 BGK collision node: lattice directions and
// velocity lane count.
// ----------------------------------------------------------------------------
package d2q9_pkg;

  localparam int NDIR       = 9;
  localparam int NVEL       = 2;
  localparam int RELAX_BITS = 22;

  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

endpackage

[rtl/d2q9_vdiv.sv]
// ----------------------------------------------------------------------------
// d2q9_vdiv
// Pipelined restoring divider, one quotient bit per stage, two lanes that
// share one divisor, with a sideband that travels in step.
// ----------------------------------------------------------------------------
module d2q9_vdiv
  import d2q9_pkg::*;
#(
  parameter int NUM_W  = 48,
  parameter int QUO_W  = 24,
  parameter int SIDE_W = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [NUM_W-1:0]                 den_i,
  input  logic [NVEL-1:0][NUM_W-1:0]       num_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic [NVEL-1:0][QUO_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]                side_o
);

  logic                       valid_q [QUO_W];
  logic [NUM_W-1:0]           den_q   [QUO_W];
  logic [NVEL-1:0][NUM_W-1:0] rem_q   [QUO_W];
  logic [NVEL-1:0][QUO_W-1:0] quo_q   [QUO_W];
  logic [SIDE_W-1:0]          side_q  [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int B = QUO_W - 1 - j;

    logic                       in_valid;
    logic [NUM_W-1:0]           in_den;
    logic [NVEL-1:0][NUM_W-1:0] in_rem;
    logic [NVEL-1:0][QUO_W-1:0] in_quo;
    logic [SIDE_W-1:0]          in_side;
    logic [NUM_W-1:0]           den_sh;
    logic [NVEL-1:0][NUM_W-1:0] rem_d;
    logic [NVEL-1:0][QUO_W-1:0] quo_d;

    if (j == 0) begin : g_first
      assign in_valid = valid_i;
      assign in_den   = den_i;
      assign in_rem   = num_i;
      assign in_quo   = '0;
      assign in_side  = side_i;
    end else begin : g_next
      assign in_valid = valid_q[j-1];
      assign in_den   = den_q[j-1];
      assign in_rem   = rem_q[j-1];
      assign in_quo   = quo_q[j-1];
      assign in_side  = side_q[j-1];
    end

    assign den_sh = in_den << B;

    always_comb begin
      for (int l = 0; l < NVEL; l++) begin
        if (in_rem[l] >= den_sh) begin
          rem_d[l] = in_rem[l] - den_sh;
          quo_d[l] = {in_quo[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[l] = in_rem[l];
          quo_d[l] = {in_quo[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j]  <= in_den;
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        side_q[j] <= in_side;
      end
    end
  end

  assign valid_o = valid_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

[rtl/d2q9_bgk_collision_node.sv]
// ----------------------------------------------------------------------------
// d2q9_bgk_collision_node
// D2Q9 BGK collision for one lattice node per beat: density, velocity and
// nine relaxed distributions in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one node per beat: the nine streamed distributions.
//   m_axis returns one beat per node: density, vel_x, vel_y, post_0..post_8.
//   cfg carries inverse_relax; write it only while no node is in flight.
// Throughput: one node per cycle, back to back, while s_axis_tready stays high.
// Pipeline: the sum and density stages, the restoring velocity divider (one
//   quotient bit per stage, WORD_BITS stages), then the velocity, square,
//   equilibrium, relaxation and output stages.
// Stall: the pipeline advances as a whole; a skid register behind the output
//   register takes the beat leaving the pipeline when the receiver stalls, so
//   s_axis_tready drops only once both hold a beat. Nothing is lost or
//   repeated.
// Reset: clears all valid bits and the skid, and sets inverse_relax to 1.0.
// ----------------------------------------------------------------------------
module d2q9_bgk_collision_node
  import d2q9_pkg::*;
#(
  parameter int FRAC_BITS = 20,
  parameter int WORD_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // dist_0 .. dist_8, WORD_BITS each, lowest first
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [((9*WORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // density, vel_x, vel_y, post_0 .. post_8, WORD_BITS each, lowest first
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [((12*WORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [RELAX_BITS-1:0] cfg_data_i
);

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int OUT_W  = ((12*W+7)/8)*8;
  localparam int RES_W  = 12*W;
  localparam int SW     = W + 4;
  localparam int MW     = W + 3;
  localparam int NUM_W  = ((MW + F > 2*W) ? MW + F : 2*W) + 1;
  localparam int SIDE_W = (NDIR + 1)*W + 5;
  localparam int SQW    = 2*W + 2;
  localparam int E2W    = SQW - F;
  localparam int PA     = 2*W - F + 5;
  localparam int PB     = (W + 4 > F + 2) ? W + 4 : F + 2;
  localparam int PW     = ((PA > PB) ? PA : PB) + 1;
  localparam int RPW    = W + PW - F;
  localparam int WTW    = F + 2;
  localparam int FW     = RPW;
  localparam int DFW    = FW + 1;
  localparam int RXW    = RELAX_BITS + 1;
  localparam int DRW    = DFW + RXW - F;
  localparam int PSW    = DRW + 1;

  localparam longint ONE_L    = longint'(1) << F;
  localparam longint W_REST_L = (4*ONE_L + 4) / 9;
  localparam longint W_AXIS_L = (ONE_L + 4) / 9;
  localparam longint W_DIAG_L = (ONE_L + 18) / 36;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic                  en;
  logic [RELAX_BITS-1:0] relax_q;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= RELAX_BITS'(ONE_L);
    end else if (cfg_valid_i) begin
      relax_q <= cfg_data_i;
    end
  end

  // ---------------- stage 1: sums ----------------
  logic signed [W-1:0]  din   [NDIR];
  logic signed [SW-1:0] sum_d;
  logic signed [MW-1:0] mx_d, my_d;
  logic                 v1_q;
  logic signed [W-1:0]  f1_q  [NDIR];
  logic signed [SW-1:0] sum1_q;
  logic signed [MW-1:0] mx1_q, my1_q;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NDIR; k++) begin
      din[k] = s_axis_tdata[k*W +: W];
      sum_d  = sum_d + SW'(din[k]);
    end
    mx_d = MW'(din[1]) - MW'(din[3]) + MW'(din[5]) - MW'(din[6]) - MW'(din[7])
         + MW'(din[8]);
    my_d = MW'(din[2]) - MW'(din[4]) + MW'(din[5]) + MW'(din[6]) - MW'(din[7])
         - MW'(din[8]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q   <= din;
      sum1_q <= sum_d;
      mx1_q  <= mx_d;
      my1_q  <= my_d;
    end
  end

  // ---------------- stage 2: density, divider operands ----------------
  logic signed [W-1:0]        rho_d;
  logic [NVEL-1:0][MW-1:0]    mag_d;
  logic [NVEL-1:0]            neg_d, ovf_d;
  logic [NUM_W-1:0]           den_big;
  logic                       v2_q;
  logic signed [W-1:0]        f2_q [NDIR];
  logic signed [W-1:0]        rho2_q;
  logic                       rhopos2_q;
  logic [NVEL-1:0]            neg2_q, ovf2_q;
  logic [NVEL-1:0][NUM_W-1:0] num2_q;

  always_comb begin
    if (sum1_q > SW'(WMAX)) begin
      rho_d = WMAX;
    end else if (sum1_q < SW'(WMIN)) begin
      rho_d = WMIN;
    end else begin
      rho_d = W'(sum1_q);
    end
    neg_d[0] = mx1_q[MW-1];
    neg_d[1] = my1_q[MW-1];
    mag_d[0] = neg_d[0] ? MW'(-mx1_q) : MW'(mx1_q);
    mag_d[1] = neg_d[1] ? MW'(-my1_q) : MW'(my1_q);
    den_big  = NUM_W'($unsigned(rho_d)) << W;
    for (int l = 0; l < NVEL; l++) begin
      ovf_d[l] = (NUM_W'(mag_d[l]) << F) >= den_big;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_q      <= f1_q;
      rho2_q    <= rho_d;
      rhopos2_q <= !rho_d[W-1] && (rho_d != '0);
      neg2_q    <= neg_d;
      ovf2_q    <= ovf_d;
      for (int l = 0; l < NVEL; l++) begin
        num2_q[l] <= NUM_W'(mag_d[l]) << F;
      end
    end
  end

  // ---------------- velocity divider ----------------
  logic [SIDE_W-1:0]          side_in, side_out;
  logic                       vdiv;
  logic [NVEL-1:0][W-1:0]     quo;

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      side_in[k*W +: W] = f2_q[k];
    end
    side_in[NDIR*W +: W]      = rho2_q;
    side_in[(NDIR+1)*W]       = rhopos2_q;
    side_in[(NDIR+1)*W+1 +: 2] = neg2_q;
    side_in[(NDIR+1)*W+3 +: 2] = ovf2_q;
  end

  d2q9_vdiv #(
    .NUM_W  (NUM_W),
    .QUO_W  (W),
    .SIDE_W (SIDE_W)
  ) u_vdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .den_i   (NUM_W'($unsigned(rho2_q))),
    .num_i   (num2_q),
    .side_i  (side_in),
    .valid_o (vdiv),
    .quo_o   (quo),
    .side_o  (side_out)
  );

  // ---------------- stage 3: velocity; carried values ----------------
  logic signed [W-1:0] ux_q  [3:10];
  logic signed [W-1:0] uy_q  [3:10];
  logic signed [W-1:0] rho_q [3:10];
  logic signed [W-1:0] fp_q  [NDIR][3:9];
  logic signed [W-1:0] u_d   [NVEL];
  logic                v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;

  always_comb begin
    for (int l = 0; l < NVEL; l++) begin
      if (!side_out[(NDIR+1)*W]) begin
        u_d[l] = '0;
      end else if (side_out[(NDIR+1)*W+1+l]) begin
        u_d[l] = (side_out[(NDIR+1)*W+3+l] || quo[l][W-1]) ? WMIN : -$signed(quo[l]);
      end else begin
        u_d[l] = (side_out[(NDIR+1)*W+3+l] || quo[l][W-1]) ? WMAX : $signed(quo[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q[3]  <= u_d[0];
      uy_q[3]  <= u_d[1];
      rho_q[3] <= side_out[NDIR*W +: W];
      for (int k = 0; k < NDIR; k++) begin
        fp_q[k][3] <= side_out[k*W +: W];
        for (int i = 4; i <= 9; i++) begin
          fp_q[k][i] <= fp_q[k][i-1];
        end
      end
      for (int i = 4; i <= 10; i++) begin
        ux_q[i]  <= ux_q[i-1];
        uy_q[i]  <= uy_q[i-1];
        rho_q[i] <= rho_q[i-1];
      end
    end
  end

  // ---------------- stage 4: squares ----------------
  logic signed [W:0]     upl, umi;
  logic [SQW-1:0]        sqx_q, sqy_q, sqp_q, sqm_q;

  assign upl = (W+1)'(ux_q[3]) + (W+1)'(uy_q[3]);
  assign umi = (W+1)'(ux_q[3]) - (W+1)'(uy_q[3]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= SQW'($unsigned(SQW'(ux_q[3]) * SQW'(ux_q[3])));
      sqy_q <= SQW'($unsigned(SQW'(uy_q[3]) * SQW'(uy_q[3])));
      sqp_q <= SQW'($unsigned(SQW'(upl) * SQW'(upl)));
      sqm_q <= SQW'($unsigned(SQW'(umi) * SQW'(umi)));
    end
  end

  // ---------------- stages 5..10 per direction ----------------
  logic [SQW-1:0] uu_sum;
  logic [PW-1:0]  uu_x, t3;

  assign uu_sum = sqx_q + sqy_q;
  assign uu_x   = PW'(uu_sum >> F);
  assign t3     = ((uu_x << 1) + uu_x) >> 1;

  logic signed [W-1:0] post_q [NDIR];

  for (genvar k = 0; k < NDIR; k++) begin : g_dir
    localparam int     DX = DIR_X[k];
    localparam int     DY = DIR_Y[k];
    localparam longint WK = (k == 0) ? W_REST_L : ((k < 5) ? W_AXIS_L : W_DIAG_L);
    localparam logic signed [WTW-1:0] WGT = WTW'(WK);

    logic signed [W+1:0]     ex, ey, eu;
    logic [SQW-1:0]          sq_sel;
    logic [PW-1:0]           e2x, t9;
    logic signed [PW-1:0]    eus, poly_d;
    logic signed [W+PW-1:0]  rp_full;
    logic signed [RPW+WTW-1:0] fq_full;
    logic signed [DFW+RXW-1:0] dr_full;
    logic signed [PSW-1:0]   ps;

    logic signed [PW-1:0]    poly5_q;
    logic signed [RPW-1:0]   rp6_q;
    logic signed [FW-1:0]    feq7_q;
    logic signed [DFW-1:0]   diff8_q;
    logic signed [DRW-1:0]   dr9_q;

    always_comb begin
      ex = (DX == 1) ? (W+2)'(ux_q[4]) : ((DX == -1) ? -(W+2)'(ux_q[4]) : '0);
      ey = (DY == 1) ? (W+2)'(uy_q[4]) : ((DY == -1) ? -(W+2)'(uy_q[4]) : '0);
      eu = ex + ey;
      if (DX == 0 && DY == 0) begin
        sq_sel = '0;
      end else if (DY == 0) begin
        sq_sel = sqx_q;
      end else if (DX == 0) begin
        sq_sel = sqy_q;
      end else if (DX == DY) begin
        sq_sel = sqp_q;
      end else begin
        sq_sel = sqm_q;
      end
      e2x    = PW'(E2W'(sq_sel >> F));
      t9     = ((e2x << 3) + e2x) >> 1;
      eus    = PW'(eu);
      poly_d = PW'(ONE_L) + (eus <<< 1) + eus + $signed(t9) - $signed(t3);
      rp_full = (W+PW)'(rho_q[5]) * (W+PW)'(poly5_q);
      fq_full = (RPW+WTW)'(rp6_q) * (RPW+WTW)'(WGT);
      dr_full = (DFW+RXW)'(diff8_q) * $signed((DFW+RXW)'({1'b0, relax_q}));
      ps      = PSW'(fp_q[k][9]) + PSW'(dr9_q);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        poly5_q <= poly_d;
        rp6_q   <= RPW'(rp_full >>> F);
        feq7_q  <= FW'(fq_full >>> F);
        diff8_q <= DFW'(feq7_q) - DFW'(fp_q[k][7]);
        dr9_q   <= DRW'(dr_full >>> F);
        if (ps > PSW'(WMAX)) begin
          post_q[k] <= WMAX;
        end else if (ps < PSW'(WMIN)) begin
          post_q[k] <= WMIN;
        end else begin
          post_q[k] <= W'(ps);
        end
      end
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else if (en) begin
      v1_q  <= s_axis_tvalid;
      v2_q  <= v1_q;
      v3_q  <= vdiv;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  // ---------------- output register and skid ----------------
  logic [RES_W-1:0] tail;
  logic             m_valid_q, skid_valid_q;
  logic [RES_W-1:0] m_data_q, skid_data_q;
  logic             out_free;

  always_comb begin
    tail[0 +: W]   = rho_q[10];
    tail[W +: W]   = ux_q[10];
    tail[2*W +: W] = uy_q[10];
    for (int k = 0; k < NDIR; k++) begin
      tail[(3+k)*W +: W] = post_q[k];
    end
  end

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q    <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        m_valid_q    <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_free) begin
      m_valid_q <= v10_q;
    end else if (v10_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        m_data_q <= skid_data_q;
      end
    end else if (out_free) begin
      m_data_q <= tail;
    end else begin
      skid_data_q <= tail;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'(m_data_q);

endmodule
